/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers on clk, with and without the reset gate.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/orpd_pkg.sv */
// ----------------------------------------------------------------------------
// orpd_pkg
// Types and constants for the optical run-length preamble detector.
// ----------------------------------------------------------------------------
package orpd_pkg;

  localparam int unsigned PREAMBLE_BITS = 8;

  // register indexes on the config port
  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_MIN_RUN    = 3'd1;
  localparam logic [2:0] REG_MAX_RUN    = 3'd2;
  localparam logic [2:0] REG_MIN_DOUBLE = 3'd3;
  localparam logic [2:0] REG_MAX_DOUBLE = 3'd4;
  localparam logic [2:0] REG_PATTERN    = 3'd5;

  // status codes as reported in the result beat
  localparam logic [2:0] STATUS_IDLE     = 3'd0;
  localparam logic [2:0] STATUS_RECV     = 3'd1;
  localparam logic [2:0] STATUS_MATCHED  = 3'd2;
  localparam logic [2:0] STATUS_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_TIMING   = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_RECV     = 5'b00010,
    PH_MATCHED  = 5'b00100,
    PH_MISMATCH = 5'b01000,
    PH_TIMING   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [3:0] bits_matched;
    logic [1:0] bit_values;
    logic [1:0] new_bits;
    logic [2:0] status;
  } result_t;

  function automatic logic [2:0] status_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_RECV:     code = STATUS_RECV;
      PH_MATCHED:  code = STATUS_MATCHED;
      PH_MISMATCH: code = STATUS_MISMATCH;
      PH_TIMING:   code = STATUS_TIMING;
      default:     code = STATUS_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* src/optical_run_length_preamble_detector.sv */
// ----------------------------------------------------------------------------
// optical_run_length_preamble_detector
// Thresholds light samples, decodes run lengths to bits, matches a preamble.
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out. A beat is taken into an input
// register, then run lengths, bit decode and pattern match are resolved
// combinationally into the result register. A new sample is taken every cycle
// as long as the result side keeps up. The result
// register frees the input side while a result still waits. Config writes are
// taken at once (cfg_ready is always high) and belong in idle periods only.
`include "assert_macros.svh"

module optical_run_length_preamble_detector (
  input  logic        clk,
  input  logic        rst,
  // sample input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic        s_tuser,   // [0] arm
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [4:3] new_bits, [6:5] bit_values,
                                 // [10:7] bits_matched, [15:11] zero
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // config registers
  logic [7:0] threshold;
  logic [3:0] min_run;
  logic [3:0] max_run;
  logic [7:0] min_double;
  logic [7:0] max_double;
  logic [7:0] expected_pattern;

  // input stage
  logic       in_valid;
  logic [7:0] in_sample;
  logic       in_arm;
  logic       advance;

  // detector state
  orpd_pkg::phase_t phase, phase_next;
  logic       seen_first_low, seen_first_low_next;
  logic [7:0] high_run, high_run_next;
  logic [3:0] low_run, low_run_next;
  logic [3:0] match_position, match_position_next;

  // result stage
  logic              out_valid;
  orpd_pkg::result_t result, result_next;

  logic       is_high;
  logic       timing_err;
  logic [1:0] nbits;
  logic [1:0] vals;
  logic [4:0] low_sum;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {5'b0, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= 8'd154;
      min_run          <= 4'd4;
      max_run          <= 4'd6;
      min_double       <= 8'd8;
      max_double       <= 8'd12;
      expected_pattern <= 8'd86;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        orpd_pkg::REG_THRESHOLD:  threshold        <= cfg_data;
        orpd_pkg::REG_MIN_RUN:    min_run          <= cfg_data[3:0];
        orpd_pkg::REG_MAX_RUN:    max_run          <= cfg_data[3:0];
        orpd_pkg::REG_MIN_DOUBLE: min_double       <= cfg_data;
        orpd_pkg::REG_MAX_DOUBLE: max_double       <= cfg_data;
        orpd_pkg::REG_PATTERN:    expected_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata;
      in_arm    <= s_tuser;
    end
  end

  always_comb begin
    phase_next          = phase;
    seen_first_low_next = seen_first_low;
    high_run_next       = high_run;
    low_run_next        = low_run;
    match_position_next = match_position;
    nbits               = 2'd0;
    vals                = 2'd0;
    timing_err          = 1'b0;
    is_high             = in_sample > threshold;
    low_sum             = {1'b0, low_run} + 5'd1;

    if (in_arm) begin
      phase_next          = orpd_pkg::PH_RECV;
      seen_first_low_next = 1'b0;
      high_run_next       = 8'd0;
      low_run_next        = 4'd0;
      match_position_next = 4'd0;
    end else if (phase == orpd_pkg::PH_RECV) begin
      if (is_high) begin
        // leading light before the first dark sample is ignored
        if (seen_first_low) begin
          if (low_run >= min_run && low_run <= max_run) begin
            nbits        = 2'd1;
            vals         = 2'b00;
            low_run_next = 4'd0;
          end else if (low_run != 4'd0) begin
            timing_err = 1'b1;
          end
          if (high_run != 8'hFF) begin
            high_run_next = high_run + 8'd1;
          end
        end
      end else begin
        seen_first_low_next = 1'b1;
        if (high_run >= {4'b0, min_run} && high_run <= {4'b0, max_run}) begin
          nbits         = 2'd1;
          vals          = 2'b01;
          high_run_next = 8'd0;
        end else if (high_run >= min_double && high_run <= max_double) begin
          nbits         = 2'd2;
          vals          = 2'b11;
          high_run_next = 8'd0;
        end else if (high_run != 8'd0) begin
          timing_err = 1'b1;
        end
        if (low_sum > {1'b0, max_run}) begin
          timing_err = 1'b1;
        end
        low_run_next = low_sum[4] ? 4'hF : low_sum[3:0];
      end

      // first decoded bit
      if (nbits != 2'd0) begin
        if (expected_pattern[match_position[2:0]] != vals[0]) begin
          phase_next = orpd_pkg::PH_MISMATCH;
        end else begin
          match_position_next = match_position + 4'd1;
          if (match_position_next >= 4'(orpd_pkg::PREAMBLE_BITS)) begin
            phase_next = orpd_pkg::PH_MATCHED;
          end
        end
      end
      // second bit only counts if matching is still open
      if (nbits == 2'd2 && phase_next == orpd_pkg::PH_RECV) begin
        if (expected_pattern[match_position_next[2:0]] != vals[1]) begin
          phase_next = orpd_pkg::PH_MISMATCH;
        end else begin
          match_position_next = match_position_next + 4'd1;
          if (match_position_next >= 4'(orpd_pkg::PREAMBLE_BITS)) begin
            phase_next = orpd_pkg::PH_MATCHED;
          end
        end
      end
      if (timing_err && phase_next == orpd_pkg::PH_RECV) begin
        phase_next = orpd_pkg::PH_TIMING;
      end
    end

    result_next.status       = orpd_pkg::status_code(phase_next);
    result_next.new_bits     = nbits;
    result_next.bit_values   = vals;
    result_next.bits_matched = match_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= orpd_pkg::PH_IDLE;
      seen_first_low <= 1'b0;
      high_run       <= 8'd0;
      low_run        <= 4'd0;
      match_position <= 4'd0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (advance && in_valid) begin
        phase          <= phase_next;
        seen_first_low <= seen_first_low_next;
        high_run       <= high_run_next;
        low_run        <= low_run_next;
        match_position <= match_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK(a_pos_bound, match_position <= 4'(orpd_pkg::PREAMBLE_BITS), "match position past preamble length")
  `ASSERT_CLK(a_matched_full, phase == orpd_pkg::PH_MATCHED |-> match_position == 4'(orpd_pkg::PREAMBLE_BITS), "matched without full preamble")
  `ASSERT_CLK(a_double_ones, out_valid && result.new_bits == 2'd2 |-> result.bit_values == 2'b11, "double bit not two ones")
  `ASSERT_CLK(a_no_bits_zero, out_valid && result.new_bits == 2'd0 |-> result.bit_values == 2'b00, "bit values without decoded bits")
  `ASSERT_CLK(a_arm_starts, advance && in_valid && in_arm |=> phase == orpd_pkg::PH_RECV && match_position == 4'd0, "arm did not restart reception")

endmodule

/* dv/tb_optical_run_length_preamble_detector.sv */
// ----------------------------------------------------------------------------
// tb_optical_run_length_preamble_detector
// Self-checking bench for the optical run-length preamble detector.
// ----------------------------------------------------------------------------
// A queue-fed driver offers sample beats and a monitor checks every result
// beat against a cycle-free model of the run-length decoder and preamble
// matcher. A short directed run comes first, then config phases with
// well-formed preambles, damaged runs and noise under varying backpressure.
// ----------------------------------------------------------------------------
module tb_optical_run_length_preamble_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] smp;
    logic       arm;
  } sample_beat_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;   // [7:0] sample
  logic        s_tuser   = 1'b0;   // [0] arm
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;            // [2:0] status, [4:3] new_bits, [6:5] bit_values,
                                   // [10:7] bits_matched
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = orpd_pkg::REG_THRESHOLD;
  logic [7:0]  cfg_data  = 8'd0;

  sample_beat_t        sample_q[$];
  orpd_pkg::result_t   result_q[$];

  int  err_count   = 0;
  int  cycle_count = 0;
  int  items_made  = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  in_taken    = 1'b0;
  bit  hold_go     = 1'b0;
  bit  hold_rx     = 1'b0;

  // detector copy: config
  logic [7:0] thr_r     = 8'd154;
  logic [3:0] min_run_r = 4'd4;
  logic [3:0] max_run_r = 4'd6;
  logic [7:0] min_dbl_r = 8'd8;
  logic [7:0] max_dbl_r = 8'd12;
  logic [7:0] pattern_r = 8'd86;
  // detector copy: state
  logic [2:0] rx_phase  = orpd_pkg::STATUS_IDLE;
  logic       low_seen  = 1'b0;
  logic [7:0] high_len  = 8'd0;
  logic [3:0] low_len   = 4'd0;
  logic [3:0] match_pos = 4'd0;

  optical_run_length_preamble_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------
  function automatic void match_preamble_bit(logic b);
    logic want;
    if (rx_phase != orpd_pkg::STATUS_RECV) return;
    want = pattern_r[match_pos[2:0]];
    if (want != b) begin
      rx_phase = orpd_pkg::STATUS_MISMATCH;
      return;
    end
    match_pos = match_pos + 4'd1;
    if (match_pos >= orpd_pkg::PREAMBLE_BITS) rx_phase = orpd_pkg::STATUS_MATCHED;
  endfunction

  function automatic orpd_pkg::result_t detect_step(logic [7:0] smp, logic arm_bit);
    orpd_pkg::result_t r;
    logic [1:0] nb;
    logic [1:0] vals;
    logic       terr;
    logic [4:0] nxt;
    nb   = 2'd0;
    vals = 2'd0;
    terr = 1'b0;
    if (arm_bit) begin
      rx_phase  = orpd_pkg::STATUS_RECV;
      low_seen  = 1'b0;
      high_len  = 8'd0;
      low_len   = 4'd0;
      match_pos = 4'd0;
    end else if (rx_phase == orpd_pkg::STATUS_RECV) begin
      if (smp > thr_r) begin
        // leading light is ignored until the first dark sample
        if (low_seen) begin
          if (low_len >= min_run_r && low_len <= max_run_r) begin
            nb      = 2'd1;
            vals    = 2'd0;
            low_len = 4'd0;
          end else if (low_len != 4'd0) begin
            terr = 1'b1;
          end
          if (high_len != 8'hFF) high_len = high_len + 8'd1;
        end
      end else begin
        low_seen = 1'b1;
        if (high_len >= min_run_r && high_len <= max_run_r) begin
          nb       = 2'd1;
          vals     = 2'd1;
          high_len = 8'd0;
        end else if (high_len >= min_dbl_r && high_len <= max_dbl_r) begin
          nb       = 2'd2;
          vals     = 2'd3;
          high_len = 8'd0;
        end else if (high_len != 8'd0) begin
          terr = 1'b1;
        end
        nxt = {1'b0, low_len} + 5'd1;
        if (nxt > max_run_r) terr = 1'b1;
        low_len = (nxt > 5'd15) ? 4'd15 : nxt[3:0];
      end
      if (nb >= 2'd1) match_preamble_bit(vals[0]);
      if (nb >= 2'd2) match_preamble_bit(vals[1]);
      // pattern outcome wins over a timing fault on the same sample
      if (terr && rx_phase == orpd_pkg::STATUS_RECV) rx_phase = orpd_pkg::STATUS_TIMING;
    end
    r.status       = rx_phase;
    r.new_bits     = nb;
    r.bit_values   = vals;
    r.bits_matched = match_pos;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driver and receiver ready
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drv
    sample_beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        b = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= b.smp;
        s_tuser  <= b.arm;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // long result stall while the sender keeps offering
  initial begin : rx_hold
    wait (hold_go);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    orpd_pkg::result_t got;
    orpd_pkg::result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(detect_step(s_tdata, s_tuser));
        in_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[10:0];
        if (result_q.size() == 0) begin
          if (err_count < 10)
            $display("ERROR: result beat with none expected: %h", m_tdata);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.new_bits !== want.new_bits ||
              got.bit_values !== want.bit_values ||
              got.bits_matched !== want.bits_matched) begin
            if (err_count < 10)
              $display("ERROR: status %0d/%0d new_bits %0d/%0d bits %0d/%0d matched %0d/%0d %s",
                       want.status, got.status, want.new_bits, got.new_bits,
                       want.bit_values, got.bit_values, want.bits_matched,
                       got.bits_matched, "(expected/actual)");
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_item(logic [7:0] smp, logic arm_bit);
    sample_beat_t b;
    b.smp = smp;
    b.arm = arm_bit;
    sample_q.push_back(b);
    items_made++;
  endfunction

  function automatic logic [7:0] lo_sample();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return thr_r;
      default: return 8'($urandom_range(thr_r, 0));
    endcase
  endfunction

  function automatic logic [7:0] hi_sample();
    if (thr_r == 8'hFF) return 8'hFF;
    case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return thr_r + 8'd1;
      default: return 8'($urandom_range(255, thr_r + 1));
    endcase
  endfunction

  function automatic void push_run(bit light, int n);
    for (int k = 0; k < n; k++) push_item(light ? hi_sample() : lo_sample(), 1'b0);
  endfunction

  function automatic int single_len();
    if (min_run_r <= max_run_r) return $urandom_range(max_run_r, min_run_r);
    return $urandom_range(15, 1);
  endfunction

  function automatic int double_len();
    int n;
    if (min_dbl_r > max_dbl_r) return $urandom_range(20, 1);
    n = $urandom_range(max_dbl_r, min_dbl_r);
    // push past the 255 ceiling of the light counter now and then
    if (max_dbl_r == 8'hFF && $urandom_range(1)) n += $urandom_range(10, 1);
    return n;
  endfunction

  // preamble that alternating dark singles and light single/double runs can carry
  function automatic logic [7:0] encodable_pattern();
    logic [7:0] p;
    int         i;
    bit         dark;
    p    = 8'd0;
    i    = 0;
    dark = 1'b1;
    while (i < 8) begin
      if (dark) begin
        i++;
      end else if (i < 7 && $urandom_range(1)) begin
        p[i]   = 1'b1;
        p[i+1] = 1'b1;
        i += 2;
      end else begin
        p[i] = 1'b1;
        i++;
      end
      dark = !dark;
    end
    return p;
  endfunction

  // one reception: arm, leading light, runs for the pattern, closing sample
  function automatic void make_frame(logic [7:0] pat, int damage_pct);
    int i;
    int n;
    bit dark;
    push_item(8'($urandom_range(255, 0)), 1'b1);
    push_run(1'b1, $urandom_range(3, 0));
    i    = 0;
    dark = 1'b1;
    while (i < 8) begin
      if (dark) begin
        n = single_len();
        i++;
      end else if (i < 7 && pat[i] && pat[i+1]) begin
        n = double_len();
        i += 2;
      end else begin
        n = single_len();
        i++;
      end
      if ($urandom_range(99) < damage_pct) n = $urandom_range(20, 1);
      push_run(!dark, n);
      dark = !dark;
    end
    push_run(!dark, 1);
    for (int k = $urandom_range(2, 0); k > 0; k--)
      push_item(8'($urandom_range(255, 0)), 1'b0);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      orpd_pkg::REG_THRESHOLD:  thr_r     = val;
      orpd_pkg::REG_MIN_RUN:    min_run_r = val[3:0];
      orpd_pkg::REG_MAX_RUN:    max_run_r = val[3:0];
      orpd_pkg::REG_MIN_DOUBLE: min_dbl_r = val;
      orpd_pkg::REG_MAX_DOUBLE: max_dbl_r = val;
      orpd_pkg::REG_PATTERN:    pattern_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] thr, logic [3:0] mn, logic [3:0] mx,
                            logic [7:0] md, logic [7:0] mdx, logic [7:0] pat);
    cfg_write(orpd_pkg::REG_THRESHOLD, thr);
    cfg_write(orpd_pkg::REG_MIN_RUN, {4'd0, mn});
    cfg_write(orpd_pkg::REG_MAX_RUN, {4'd0, mx});
    cfg_write(orpd_pkg::REG_MIN_DOUBLE, md);
    cfg_write(orpd_pkg::REG_MAX_DOUBLE, mdx);
    cfg_write(orpd_pkg::REG_PATTERN, pat);
  endtask

  task automatic drain();
    @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int         start;
    int         budget;
    logic [3:0] mn;
    logic [3:0] mx;
    logic [7:0] md;
    logic [7:0] pat;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // samples before any arm are ignored
    push_item(8'd0, 1'b0);
    push_item(8'hFF, 1'b0);
    drain();

    // short runs: single 1..2, double 3..4, preamble 0,1,1,0,1,0,1,0
    set_config(8'd154, 4'd1, 4'd2, 8'd3, 8'd4, 8'd86);
    push_item(8'hFF, 1'b1);
    push_item(8'hFF, 1'b0);          // leading light, ignored
    push_item(8'd154, 1'b0);         // threshold itself counts as dark
    push_run(1'b1, 0);
    push_item(8'd155, 1'b0);
    push_item(8'd200, 1'b0);
    push_item(8'd155, 1'b0);         // three light samples: two ones
    push_item(8'd0, 1'b0);
    push_item(8'd0, 1'b0);
    push_item(8'd200, 1'b0);
    push_item(8'd10, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd100, 1'b0);
    push_item(8'd255, 1'b0);         // last zero: matched
    push_item(8'd0, 1'b0);           // held while matched
    // dark run past the maximum
    push_item(8'd77, 1'b1);
    push_item(8'd0, 1'b0);
    push_item(8'd0, 1'b0);
    push_item(8'd0, 1'b0);
    // a zero where a one is due
    push_item(8'd0, 1'b1);
    push_item(8'd0, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'd0, 1'b0);
    push_item(8'hFF, 1'b0);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 36; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 36; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      budget = 20;
      case (p)
        0: set_config(8'd154, 4'd4, 4'd6, 8'd8, 8'd12, 8'd86);
        1: set_config(8'd0, 4'd1, 4'd1, 8'd2, 8'd2, encodable_pattern());
        2: begin
          set_config(8'd255, 4'd15, 4'd15, 8'd255, 8'd255, 8'd0);
          make_frame(pattern_r, 0);
          budget = 0;
        end
        3: begin
          set_config(8'd128, 4'd2, 4'd3, 8'd250, 8'd255, 8'd86);
          make_frame(pattern_r, 0);
          budget = 0;
        end
        4: set_config(8'd100, 4'd6, 4'd3, 8'd9, 8'd5, encodable_pattern());
        default: begin
          mn  = 4'($urandom_range(6, 1));
          mx  = 4'($urandom_range(8, mn));
          md  = 8'($urandom_range(mx + 6, mx + 1));
          pat = ($urandom_range(99) < 80) ? encodable_pattern() : 8'($urandom_range(255));
          set_config(8'($urandom_range(250, 5)), mn, mx, md,
                     8'($urandom_range(md + 4, md)), pat);
        end
      endcase
      if (p == 7) hold_go = 1'b1;
      start = items_made;
      while (items_made - start < budget) begin
        case ($urandom_range(9))
          0, 1: begin
            for (int k = $urandom_range(8, 1); k > 0; k--)
              push_item(8'($urandom_range(255)), $urandom_range(99) < 10);
          end
          2:       make_frame(encodable_pattern(), 5);
          default: make_frame(pattern_r, 8);
        endcase
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
